/* rtl/core/ppm_pkg.sv */
// Package for the PPM image stream parser: parse phases, character codes,
// result kinds, error codes and the structs passed between the parser modules.
// Depends on nothing; every RTL file of the parser refers to it by scoped names.
`default_nettype none

package ppm_pkg;

	// Largest accepted width or height, and the limit after capping at the
	// range of the row and column fields.
	localparam int MAX_DIM   = 4096;
	localparam int DIM_LIMIT = (MAX_DIM < 4096) ? MAX_DIM : 4096;

	localparam int DIM_W = 13;
	localparam int POS_W = 12;
	localparam int ACC_W = 24;
	localparam int NV_W  = ACC_W + 4;

	localparam logic [ACC_W-1:0] ACC_MAX   = 24'hFF_FFFF;
	localparam logic [ACC_W-1:0] ACC_DIV10 = ACC_MAX / 10;
	localparam logic [ACC_W-1:0] DIM_MAX   = ACC_W'(DIM_LIMIT);
	localparam logic [ACC_W-1:0] MAXVAL_FULL = 24'd255;

	// Character codes.
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_3     = 8'h33;
	localparam logic [7:0] CH_6     = 8'h36;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// Result kinds.
	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes.
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_MAGIC = 2'd1;
	localparam logic [1:0] ERR_CHAR  = 2'd2;
	localparam logic [1:0] ERR_RANGE = 2'd3;

	typedef enum logic [2:0] {
		PH_MAGIC1 = 3'd0,
		PH_MAGIC2 = 3'd1,
		PH_WIDTH  = 3'd2,
		PH_HEIGHT = 3'd3,
		PH_MAXVAL = 3'd4,
		PH_PIXELS = 3'd5,
		PH_STOP   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		NUM_NONE     = 2'd0,
		NUM_DONE     = 2'd1,
		NUM_BADCHAR  = 2'd2,
		NUM_OVERFLOW = 2'd3
	} num_status_t;

	// State of the decimal number reader.
	typedef struct packed {
		logic             in_comment;
		logic             got_digit;
		logic [ACC_W-1:0] accumulator;
		logic             accum_overflow;
	} num_state_t;

	// Complete parser state; the all-zero value is the state after reset.
	typedef struct packed {
		phase_t           phase;
		logic             binary_mode;
		num_state_t       num;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [POS_W-1:0] column_count;
		logic [POS_W-1:0] line_count;
		logic [1:0]       channel_index;
		logic [7:0]       red_hold;
		logic [7:0]       green_hold;
	} core_state_t;

	localparam core_state_t STATE_CLEAR = '0;

	// One result item.
	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] column;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic             maxval_is_255;
		logic [1:0]       error_code;
		logic             last;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/ppm_number_reader.sv */
// Decimal number reader of the PPM parser: digits, comments, whitespace.
// Purely combinational; depends on ppm_pkg.
`default_nettype none

module ppm_number_reader (
	input  wire logic [7:0]                 data_byte,
	input  wire ppm_pkg::num_state_t        cur,
	output ppm_pkg::num_status_t            status,
	output logic [ppm_pkg::ACC_W-1:0]       value,
	output ppm_pkg::num_state_t             nxt
);

	logic                      is_digit;
	logic                      is_space;
	logic [ppm_pkg::NV_W-1:0]  acc_wide;
	logic [ppm_pkg::NV_W-1:0]  times_ten;
	logic                      too_big;

	assign is_digit = data_byte inside {[ppm_pkg::CH_0:ppm_pkg::CH_9]};
	assign is_space = data_byte inside {ppm_pkg::CH_SPACE, ppm_pkg::CH_TAB,
		ppm_pkg::CH_CR, ppm_pkg::CH_LF};

	// acc * 10 + digit as two shifts and two adds.
	assign acc_wide  = {4'b0000, cur.accumulator};
	assign times_ten = (acc_wide << 3) + (acc_wide << 1) + {24'd0, data_byte[3:0]};
	assign too_big   = (cur.accumulator > ppm_pkg::ACC_DIV10) ||
		(times_ten > {4'b0000, ppm_pkg::ACC_MAX});

	always_comb begin
		nxt    = cur;
		status = ppm_pkg::NUM_NONE;
		value  = cur.accumulator;
		if (cur.in_comment) begin
			if (data_byte == ppm_pkg::CH_LF) begin
				nxt.in_comment = 1'b0;
			end
		end else if (is_digit) begin
			nxt.accumulator    = too_big ? ppm_pkg::ACC_MAX : times_ten[ppm_pkg::ACC_W-1:0];
			nxt.accum_overflow = cur.accum_overflow | too_big;
			nxt.got_digit      = 1'b1;
		end else if (data_byte == ppm_pkg::CH_HASH) begin
			nxt.in_comment = 1'b1;
		end else if (is_space) begin
			if (cur.got_digit) begin
				status = cur.accum_overflow ? ppm_pkg::NUM_OVERFLOW : ppm_pkg::NUM_DONE;
				nxt.accumulator    = '0;
				nxt.got_digit      = 1'b0;
				nxt.accum_overflow = 1'b0;
			end
		end else begin
			status = ppm_pkg::NUM_BADCHAR;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/ppm_parser_core.sv */
// Parser state registers of the PPM parser and the per-byte update logic that
// decides the next state and the result of one byte. Depends on ppm_pkg and
// ppm_number_reader.
`default_nettype none

module ppm_parser_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic [7:0]       data_byte,
	input  wire logic             start_of_file,
	output logic                  has_result,
	output ppm_pkg::result_t      result
);

	ppm_pkg::core_state_t  state_q;
	ppm_pkg::core_state_t  cur;
	ppm_pkg::core_state_t  nxt;

	ppm_pkg::num_status_t            num_status;
	logic [ppm_pkg::ACC_W-1:0]       num_value;
	ppm_pkg::num_state_t             num_next;

	logic                            num_error;
	logic                            dim_too_big;
	logic [7:0]                      sample;
	logic                            sample_ready;
	logic [ppm_pkg::DIM_W-1:0]       col_plus;
	logic [ppm_pkg::DIM_W-1:0]       line_plus;
	logic [ppm_pkg::DIM_W-1:0]       row_full;
	logic                            row_wrap;
	logic                            final_pixel;
	logic                            empty_image;

	// A restart clears everything before the byte is looked at.
	assign cur = start_of_file ? ppm_pkg::STATE_CLEAR : state_q;

	ppm_number_reader u_number (
		.data_byte (data_byte),
		.cur       (cur.num),
		.status    (num_status),
		.value     (num_value),
		.nxt       (num_next)
	);

	assign num_error   = (num_status == ppm_pkg::NUM_BADCHAR) ||
		(num_status == ppm_pkg::NUM_OVERFLOW);
	assign dim_too_big = num_value > ppm_pkg::DIM_MAX;
	assign sample      = cur.binary_mode ? data_byte : num_value[7:0];
	assign sample_ready = cur.binary_mode || (num_status == ppm_pkg::NUM_DONE);

	assign col_plus    = {1'b0, cur.column_count} + 13'd1;
	assign line_plus   = {1'b0, cur.line_count} + 13'd1;
	assign row_full    = cur.height - 13'd1 - {1'b0, cur.line_count};
	assign row_wrap    = col_plus >= cur.width;
	assign final_pixel = (line_plus >= cur.height) && row_wrap;
	assign empty_image = (cur.width == '0) || (cur.height == '0);

	// Next state.
	always_comb begin
		nxt = cur;
		case (cur.phase)
			ppm_pkg::PH_MAGIC1: begin
				nxt.phase = (data_byte == ppm_pkg::CH_P) ? ppm_pkg::PH_MAGIC2 : ppm_pkg::PH_STOP;
			end
			ppm_pkg::PH_MAGIC2: begin
				if (data_byte == ppm_pkg::CH_3) begin
					nxt.binary_mode = 1'b0;
					nxt.phase       = ppm_pkg::PH_WIDTH;
				end else if (data_byte == ppm_pkg::CH_6) begin
					nxt.binary_mode = 1'b1;
					nxt.phase       = ppm_pkg::PH_WIDTH;
				end else begin
					nxt.phase = ppm_pkg::PH_STOP;
				end
			end
			ppm_pkg::PH_WIDTH, ppm_pkg::PH_HEIGHT, ppm_pkg::PH_MAXVAL: begin
				nxt.num = num_next;
				if (num_error) begin
					nxt.phase = ppm_pkg::PH_STOP;
				end else if (num_status == ppm_pkg::NUM_DONE) begin
					if (cur.phase == ppm_pkg::PH_MAXVAL) begin
						nxt.column_count  = '0;
						nxt.line_count    = '0;
						nxt.channel_index = '0;
						nxt.phase = empty_image ? ppm_pkg::PH_STOP : ppm_pkg::PH_PIXELS;
					end else if (dim_too_big) begin
						nxt.phase = ppm_pkg::PH_STOP;
					end else if (cur.phase == ppm_pkg::PH_WIDTH) begin
						nxt.width = num_value[ppm_pkg::DIM_W-1:0];
						nxt.phase = ppm_pkg::PH_HEIGHT;
					end else begin
						nxt.height = num_value[ppm_pkg::DIM_W-1:0];
						nxt.phase  = ppm_pkg::PH_MAXVAL;
					end
				end
			end
			ppm_pkg::PH_PIXELS: begin
				if (!cur.binary_mode) begin
					nxt.num = num_next;
				end
				if (!cur.binary_mode && num_error) begin
					nxt.phase = ppm_pkg::PH_STOP;
				end else if (sample_ready) begin
					case (cur.channel_index)
						2'd0: begin
							nxt.red_hold      = sample;
							nxt.channel_index = 2'd1;
						end
						2'd1: begin
							nxt.green_hold    = sample;
							nxt.channel_index = 2'd2;
						end
						default: begin
							nxt.channel_index = 2'd0;
							if (row_wrap) begin
								nxt.column_count = '0;
								nxt.line_count   = line_plus[ppm_pkg::POS_W-1:0];
							end else begin
								nxt.column_count = col_plus[ppm_pkg::POS_W-1:0];
							end
							if (final_pixel) begin
								nxt.phase = ppm_pkg::PH_STOP;
							end
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// Result of this byte.
	always_comb begin
		has_result = 1'b0;
		result     = '0;
		case (cur.phase)
			ppm_pkg::PH_MAGIC1: begin
				if (data_byte != ppm_pkg::CH_P) begin
					has_result        = 1'b1;
					result.kind       = ppm_pkg::KIND_ERROR;
					result.error_code = ppm_pkg::ERR_MAGIC;
					result.last       = 1'b1;
				end
			end
			ppm_pkg::PH_MAGIC2: begin
				if (!(data_byte inside {ppm_pkg::CH_3, ppm_pkg::CH_6})) begin
					has_result        = 1'b1;
					result.kind       = ppm_pkg::KIND_ERROR;
					result.error_code = ppm_pkg::ERR_MAGIC;
					result.last       = 1'b1;
				end
			end
			ppm_pkg::PH_WIDTH, ppm_pkg::PH_HEIGHT, ppm_pkg::PH_MAXVAL: begin
				if (num_status == ppm_pkg::NUM_BADCHAR) begin
					has_result        = 1'b1;
					result.kind       = ppm_pkg::KIND_ERROR;
					result.error_code = ppm_pkg::ERR_CHAR;
					result.last       = 1'b1;
				end else if (num_status == ppm_pkg::NUM_OVERFLOW) begin
					has_result        = 1'b1;
					result.kind       = ppm_pkg::KIND_ERROR;
					result.error_code = ppm_pkg::ERR_RANGE;
					result.last       = 1'b1;
				end else if (num_status == ppm_pkg::NUM_DONE) begin
					if (cur.phase == ppm_pkg::PH_MAXVAL) begin
						has_result           = 1'b1;
						result.kind          = ppm_pkg::KIND_HEADER;
						result.image_width   = cur.width;
						result.image_height  = cur.height;
						result.maxval_is_255 = (num_value == ppm_pkg::MAXVAL_FULL);
						result.last          = empty_image;
					end else if (dim_too_big) begin
						has_result        = 1'b1;
						result.kind       = ppm_pkg::KIND_ERROR;
						result.error_code = ppm_pkg::ERR_RANGE;
						result.last       = 1'b1;
					end
				end
			end
			ppm_pkg::PH_PIXELS: begin
				if (!cur.binary_mode && num_status == ppm_pkg::NUM_BADCHAR) begin
					has_result        = 1'b1;
					result.kind       = ppm_pkg::KIND_ERROR;
					result.error_code = ppm_pkg::ERR_CHAR;
					result.last       = 1'b1;
				end else if (!cur.binary_mode && num_status == ppm_pkg::NUM_OVERFLOW) begin
					has_result        = 1'b1;
					result.kind       = ppm_pkg::KIND_ERROR;
					result.error_code = ppm_pkg::ERR_RANGE;
					result.last       = 1'b1;
				end else if (sample_ready && cur.channel_index == 2'd2) begin
					has_result    = 1'b1;
					result.kind   = ppm_pkg::KIND_PIXEL;
					result.red    = cur.red_hold;
					result.green  = cur.green_hold;
					result.blue   = sample;
					result.row    = row_full[ppm_pkg::POS_W-1:0];
					result.column = cur.column_count;
					result.last   = final_pixel;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppm_pkg::STATE_CLEAR;
		end else if (en) begin
			state_q <= nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/ppm_image_stream_parser.sv */
// Top level of the PPM image stream parser: input register, parser core and
// result register with the valid/ready handshakes. Depends on ppm_pkg,
// ppm_parser_core and ppm_number_reader.
//
//   Channel   Direction  Handshake            Payload
//   request   in         in_valid / in_ready  data_byte, start_of_file
//   result    out        out_valid/out_ready  kind, red, green, blue, row, column,
//                                             image_width, image_height,
//                                             maxval_is_255, error_code, last
//
// One byte is taken every cycle while no result stalls; the parse state is
// updated once per byte by the core logic between the input register and the
// result register, which registers a byte's result if it has one.
// Reset clears the handshake state and the parser state at once; there is no
// clearing pass, and the first byte after reset is the first magic byte.
// A stalled result holds the result register, which holds the input register,
// which then drops in_ready; the byte in the input register waits for the
// stalled result to leave even when it has no result of its own.
`default_nettype none

module ppm_image_stream_parser (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [7:0]                  data_byte,
	input  wire logic                        start_of_file,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       kind,
	output logic [7:0]                       red,
	output logic [7:0]                       green,
	output logic [7:0]                       blue,
	output logic [ppm_pkg::POS_W-1:0]        row,
	output logic [ppm_pkg::POS_W-1:0]        column,
	output logic [ppm_pkg::DIM_W-1:0]        image_width,
	output logic [ppm_pkg::DIM_W-1:0]        image_height,
	output logic                             maxval_is_255,
	output logic [1:0]                       error_code,
	output logic                             last
);

	// Input register.
	logic              valid_s1;
	logic [7:0]        data_byte_s1;
	logic              start_s1;

	// Result register.
	logic              out_valid_q;
	ppm_pkg::result_t  result_q;

	logic              in_fire;
	logic              advance;
	logic              has_result;
	ppm_pkg::result_t  result;

	// The byte in the input register is processed whenever the result
	// register is free or being emptied in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_byte_s1 <= data_byte;
			start_s1     <= start_of_file;
		end
	end

	ppm_parser_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.data_byte     (data_byte_s1),
		.start_of_file (start_s1),
		.has_result    (has_result),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = result_q.kind;
	assign red           = result_q.red;
	assign green         = result_q.green;
	assign blue          = result_q.blue;
	assign row           = result_q.row;
	assign column        = result_q.column;
	assign image_width   = result_q.image_width;
	assign image_height  = result_q.image_height;
	assign maxval_is_255 = result_q.maxval_is_255;
	assign error_code    = result_q.error_code;
	assign last          = result_q.last;

`ifndef SYNTHESIS
	// A waiting result must never be overwritten by the next byte.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !advance)
		else $error("byte processed while a result is stalled");

	// Every error ends the stream.
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind == ppm_pkg::KIND_ERROR |-> last)
		else $error("error result without last");

	// Error codes appear on error results only, and always on them.
	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((kind == ppm_pkg::KIND_ERROR) == (error_code != ppm_pkg::ERR_NONE)))
		else $error("error code does not match result kind");

	// A byte may be taken while the input register is full only when the byte in it leaves.
	a_stage_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && valid_s1 |-> advance)
		else $error("input register overrun");
`endif

endmodule

`default_nettype wire

/* bench/ppm_result_checker.sv */
// Result checker for the PPM image stream parser: watches both channels, predicts
// every header, pixel and error result from the accepted bytes and compares them.
// Depends on ppm_pkg for the phase enum, character codes, result kinds and error codes.
module ppm_result_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       start_of_file,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [1:0]                 kind,
	input  logic [7:0]                 red,
	input  logic [7:0]                 green,
	input  logic [7:0]                 blue,
	input  logic [ppm_pkg::POS_W-1:0]  row,
	input  logic [ppm_pkg::POS_W-1:0]  column,
	input  logic [ppm_pkg::DIM_W-1:0]  image_width,
	input  logic [ppm_pkg::DIM_W-1:0]  image_height,
	input  logic                       maxval_is_255,
	input  logic [1:0]                 error_code,
	input  logic                       last,
	output int unsigned                fault_count,
	output int unsigned                pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import ppm_pkg::*;

	// Parser state as the predictor sees it.
	phase_t           parse_stage;
	logic             raw_mode;
	logic             skipping_comment;
	logic             seen_digit;
	logic [ACC_W-1:0] number_acc;
	logic             number_ovf;
	logic [DIM_W-1:0] img_width;
	logic [DIM_W-1:0] img_height;
	logic [POS_W-1:0] col_pos;
	logic [POS_W-1:0] line_pos;
	logic [1:0]       sample_idx;
	logic [7:0]       red_keep;
	logic [7:0]       green_keep;

	result_t     decoded_results[$];
	int unsigned faults;

	task automatic clear_parser();
		parse_stage      = PH_MAGIC1;
		raw_mode         = 1'b0;
		skipping_comment = 1'b0;
		seen_digit       = 1'b0;
		number_acc       = '0;
		number_ovf       = 1'b0;
		img_width        = '0;
		img_height       = '0;
		col_pos          = '0;
		line_pos         = '0;
		sample_idx       = '0;
		red_keep         = '0;
		green_keep       = '0;
	endtask

	// Decimal text reader; a number completes on the first whitespace after a digit.
	function automatic num_status_t scan_number(input logic [7:0] b,
			output logic [ACC_W-1:0] value);
		logic [NV_W-1:0] grown;
		num_status_t     status;
		value = '0;
		if (skipping_comment) begin
			if (b == CH_LF)
				skipping_comment = 1'b0;
			return NUM_NONE;
		end
		if (b >= CH_0 && b <= CH_9) begin
			grown = NV_W'(number_acc) * NV_W'(10) + NV_W'(b - CH_0);
			if (number_acc > ACC_DIV10 || grown > NV_W'(ACC_MAX)) begin
				number_ovf = 1'b1;
				grown = NV_W'(ACC_MAX);
			end
			number_acc = grown[ACC_W-1:0];
			seen_digit = 1'b1;
			return NUM_NONE;
		end
		if (b == CH_HASH) begin
			skipping_comment = 1'b1;
			return NUM_NONE;
		end
		if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
			if (!seen_digit)
				return NUM_NONE;
			status = number_ovf ? NUM_OVERFLOW : NUM_DONE;
			value = number_acc;
			number_acc = '0;
			seen_digit = 1'b0;
			number_ovf = 1'b0;
			return status;
		end
		return NUM_BADCHAR;
	endfunction

	// Advances the parser by one accepted byte and queues the result it causes.
	task automatic decode_byte(input logic [7:0] b, input logic restart);
		result_t          res;
		logic             emit;
		logic [1:0]       fault;
		logic [ACC_W-1:0] value;
		num_status_t      status;
		int unsigned      col_next;
		res = '0;
		emit = 1'b0;
		fault = ERR_NONE;
		value = '0;
		status = NUM_NONE;
		if (restart)
			clear_parser();
		case (parse_stage)
			PH_MAGIC1: begin
				if (b != CH_P)
					fault = ERR_MAGIC;
				else
					parse_stage = PH_MAGIC2;
			end
			PH_MAGIC2: begin
				if (b == CH_3 || b == CH_6) begin
					raw_mode = (b == CH_6);
					parse_stage = PH_WIDTH;
				end else begin
					fault = ERR_MAGIC;
				end
			end
			PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
				status = scan_number(b, value);
				if (status == NUM_BADCHAR) begin
					fault = ERR_CHAR;
				end else if (status == NUM_OVERFLOW) begin
					fault = ERR_RANGE;
				end else if (status == NUM_DONE && parse_stage != PH_MAXVAL) begin
					if (value > DIM_MAX) begin
						fault = ERR_RANGE;
					end else if (parse_stage == PH_WIDTH) begin
						img_width = value[DIM_W-1:0];
						parse_stage = PH_HEIGHT;
					end else begin
						img_height = value[DIM_W-1:0];
						parse_stage = PH_MAXVAL;
					end
				end else if (status == NUM_DONE) begin
					emit = 1'b1;
					res.kind = KIND_HEADER;
					res.image_width = img_width;
					res.image_height = img_height;
					res.maxval_is_255 = (value == MAXVAL_FULL);
					col_pos = '0;
					line_pos = '0;
					sample_idx = '0;
					if (img_width == '0 || img_height == '0) begin
						res.last = 1'b1;
						parse_stage = PH_STOP;
					end else begin
						parse_stage = PH_PIXELS;
					end
				end
			end
			PH_PIXELS: begin
				if (raw_mode) begin
					value = ACC_W'(b);
					status = NUM_DONE;
				end else begin
					status = scan_number(b, value);
				end
				if (status == NUM_BADCHAR) begin
					fault = ERR_CHAR;
				end else if (status == NUM_OVERFLOW) begin
					fault = ERR_RANGE;
				end else if (status == NUM_DONE) begin
					if (sample_idx == 2'd0) begin
						red_keep = value[7:0];
						sample_idx = 2'd1;
					end else if (sample_idx == 2'd1) begin
						green_keep = value[7:0];
						sample_idx = 2'd2;
					end else begin
						// Third sample of the triple: a pixel, rows counted bottom-up.
						sample_idx = 2'd0;
						emit = 1'b1;
						res.kind = KIND_PIXEL;
						res.red = red_keep;
						res.green = green_keep;
						res.blue = value[7:0];
						res.row = POS_W'(32'(img_height) - 32'd1 - 32'(line_pos));
						res.column = col_pos;
						res.last = (32'(line_pos) + 32'd1 >= 32'(img_height)) &&
							(32'(col_pos) + 32'd1 >= 32'(img_width));
						col_next = 32'(col_pos) + 32'd1;
						if (col_next >= 32'(img_width)) begin
							col_next = 0;
							line_pos = line_pos + 1'b1;
						end
						col_pos = col_next[POS_W-1:0];
						if (res.last)
							parse_stage = PH_STOP;
					end
				end
			end
			default: ;
		endcase
		if (fault != ERR_NONE) begin
			emit = 1'b1;
			res = '0;
			res.kind = KIND_ERROR;
			res.error_code = fault;
			res.last = 1'b1;
			parse_stage = PH_STOP;
		end
		if (emit)
			decoded_results.push_back(res);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			faults++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_parser();
			decoded_results.delete();
			faults = 0;
			fault_count <= 0;
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (decoded_results.size() == 0) begin
					$display("%0t ns: result kind %0d arrived with no request waiting for one",
						$time, kind);
					faults++;
				end else begin
					want = decoded_results.pop_front();
					check_field("kind", want.kind, kind);
					check_field("red", want.red, red);
					check_field("green", want.green, green);
					check_field("blue", want.blue, blue);
					check_field("row", want.row, row);
					check_field("column", want.column, column);
					check_field("image_width", want.image_width, image_width);
					check_field("image_height", want.image_height, image_height);
					check_field("maxval_is_255", want.maxval_is_255, maxval_is_255);
					check_field("error_code", want.error_code, error_code);
					check_field("last", want.last, last);
				end
			end
			if (in_valid && in_ready)
				decode_byte(data_byte, start_of_file);
			pending_count <= decoded_results.size();
			fault_count <= faults;
		end
	end

endmodule

/* bench/tb_ppm_image_stream_parser.sv */
// Testbench top for the PPM image stream parser: clock, reset, byte stimulus and verdict.
// Depends on ppm_pkg, the parser RTL and ppm_result_checker, which does all checking.
module tb_ppm_image_stream_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import ppm_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         data_byte;
	logic               start_of_file;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         kind;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic [POS_W-1:0]   row;
	logic [POS_W-1:0]   column;
	logic [DIM_W-1:0]   image_width;
	logic [DIM_W-1:0]   image_height;
	logic               maxval_is_255;
	logic [1:0]         error_code;
	logic               last;
	int unsigned        fault_count;
	int unsigned        pending_count;

	// When set, neither side idles: the sender offers a request every cycle and
	// the result side is always ready.
	logic steady;

	// Bytes of the file being built, sent one request per byte.
	logic [7:0] file_bytes[$];

	ppm_image_stream_parser i_dut (.*);

	ppm_result_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The result side drops ready at random, about 38 percent of the time, except during
	// the steady stretch.
	always @(posedge clk)
		out_ready <= steady || ($urandom_range(99) >= 38);

	// Offers one byte and holds it until the parser takes it. Random idle cycles
	// before the request put gaps between requests at every point of the file.
	task automatic send_byte(input logic [7:0] value, input logic restart);
		while (!steady && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= value;
		start_of_file <= restart;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Sends the built file; the first byte restarts parsing when restart is set.
	task automatic send_file(input logic restart);
		foreach (file_bytes[i])
			send_byte(file_bytes[i], restart && i == 0);
		file_bytes.delete();
	endtask

	task automatic add_text(input string text);
		for (int i = 0; i < text.len(); i++)
			file_bytes.push_back(text[i]);
	endtask

	task automatic add_space();
		case ($urandom_range(3))
			0: file_bytes.push_back(CH_SPACE);
			1: file_bytes.push_back(CH_TAB);
			2: file_bytes.push_back(CH_CR);
			default: file_bytes.push_back(CH_LF);
		endcase
	endtask

	// A comment may hold any byte, the zero byte included, up to the newline
	// that closes it.
	task automatic add_comment();
		logic [7:0] c;
		file_bytes.push_back(CH_HASH);
		repeat ($urandom_range(5)) begin
			c = 8'($urandom_range(255));
			file_bytes.push_back(c == CH_LF ? CH_SPACE : c);
		end
		file_bytes.push_back(CH_LF);
	endtask

	// Separator between numbers: always at least one whitespace byte, so the
	// number before it completes, sometimes followed by a comment.
	task automatic add_gap();
		add_space();
		if ($urandom_range(5) == 0)
			add_comment();
		if ($urandom_range(3) == 0)
			add_space();
	endtask

	// Decimal text of a number. Now and then it gets a leading zero, or a comment
	// splits its digits, which the parser must join back into one number.
	task automatic add_number(input int unsigned value);
		string digits;
		int    cut;
		digits = $sformatf("%0d", value);
		if ($urandom_range(7) == 0)
			file_bytes.push_back(CH_0);
		cut = ($urandom_range(7) == 0) ? $urandom_range(digits.len() - 1) : -1;
		for (int i = 0; i < digits.len(); i++) begin
			if (i == cut)
				add_comment();
			file_bytes.push_back(digits[i]);
		end
	endtask

	// A byte that is neither a digit, whitespace nor the comment mark; the zero
	// byte is favored since it is the classic case of an invalid character.
	function automatic logic [7:0] stray_char();
		logic [7:0] c;
		if ($urandom_range(3) == 0)
			return 8'h00;
		do
			c = 8'($urandom_range(255));
		while ((c >= CH_0 && c <= CH_9) || c == CH_HASH || c == CH_SPACE ||
			c == CH_TAB || c == CH_CR || c == CH_LF);
		return c;
	endfunction

	// Builds one file. Most are well formed with tiny images so that headers and
	// last pixels come often; the rest carry empty or huge dimensions, numbers too
	// large, invalid characters and bad magic bytes. Large images are cut short
	// and the next file restarts the parser in the middle of the pixel data.
	// body_len excludes trailing bytes that follow a finished file.
	task automatic build_file(output int unsigned body_len);
		logic        raw;
		int unsigned w;
		int unsigned h;
		int unsigned pick;
		int unsigned pixels;
		raw = 1'($urandom_range(1));
		file_bytes.push_back(CH_P);
		file_bytes.push_back(raw ? CH_6 : CH_3);
		if ($urandom_range(3) != 0)
			add_gap();
		w = $urandom_range(4, 1);
		h = $urandom_range(3, 1);
		pick = $urandom_range(99);
		if (pick >= 98) begin
			w = $urandom_range(99999999, 16777216);
		end else if (pick >= 94) begin
			h = $urandom_range(70000, 4097);
		end else if (pick >= 88) begin
			if ($urandom_range(1))
				w = 4096;
			else
				h = 4096;
		end else if (pick >= 82) begin
			if ($urandom_range(1))
				w = 0;
			else
				h = 0;
		end
		add_number(w);
		add_gap();
		add_number(h);
		add_gap();
		pick = $urandom_range(19);
		if (pick == 0)
			add_number($urandom_range(99999999, 16777216));
		else if (pick <= 5)
			add_number($urandom_range(65535));
		else
			add_number(255);
		// Raw samples start right after the single byte that ends the maxval.
		if (raw)
			add_space();
		else
			add_gap();
		pixels = w * h;
		if (pixels > 12)
			pixels = $urandom_range(12, 1);
		repeat (pixels * 3) begin
			if (raw) begin
				file_bytes.push_back(8'($urandom_range(255)));
			end else begin
				pick = $urandom_range(199);
				if (pick == 0)
					add_number($urandom_range(30000000, 16777216));
				else if (pick < 60)
					add_number($urandom_range(999));
				else
					add_number($urandom_range(255));
				add_gap();
			end
		end
		if ($urandom_range(11) == 0)
			file_bytes.insert($urandom_range(file_bytes.size(), 2), stray_char());
		if ($urandom_range(29) == 0)
			file_bytes[$urandom_range(1)] = 8'($urandom_range(255));
		body_len = file_bytes.size();
		// Bytes after the end of a file must be ignored until the next restart.
		if ($urandom_range(4) == 0)
			repeat ($urandom_range(3, 1))
				file_bytes.push_back(8'($urandom_range(255)));
	endtask

	initial begin
		int unsigned sent;
		int unsigned body_len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		start_of_file = 1'b0;
		out_ready = 1'b0;
		steady = 1'b0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed files. The first one comes without a restart flag, since after
		// reset the first byte is the first magic byte anyway; its raw samples
		// hold the extreme byte values and the pixel is the last of the image.
		add_text("P6 1 1 255\n");
		file_bytes.push_back(8'h00);
		file_bytes.push_back(8'hFF);
		file_bytes.push_back(8'h80);
		send_file(1'b0);
		// Bad first magic byte, then bad second magic byte.
		add_text("X");
		send_file(1'b1);
		add_text("P5");
		send_file(1'b1);
		// Header of an empty image, with a maxval other than 255.
		add_text("P3\t0\r7\n9 ");
		send_file(1'b1);
		// The zero byte where a number is expected.
		add_text("P3");
		file_bytes.push_back(8'h00);
		send_file(1'b1);

		// Random files, with a stretch in the middle where no side idles.
		sent = 0;
		while (sent < 1650) begin
			steady = (sent >= 600 && sent < 950);
			build_file(body_len);
			sent += body_len;
			send_file(1'b1);
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		// Let the last request reach the checker, drain every expected result,
		// then keep watching for any stray result from the parser.
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (12)
			@(posedge clk);
		if (fault_count == 0)
			$display("tb_ppm_image_stream_parser: clean");
		else
			$display("tb_ppm_image_stream_parser: errors");
		$finish;
	end

	// Far beyond the slowest correct run of about two thousand requests.
	initial begin
		#2000000;
		$display("tb_ppm_image_stream_parser: errors");
		$finish;
	end

endmodule
